@@ src/sdkt_pkg.sv @@
// ----------------------------------------------------------------------------
// sdkt_pkg - shared definitions for the sorted date key table
// Field widths, status codes, default sizes and the key packing function.
// ----------------------------------------------------------------------------
package sdkt_pkg;

    // default sizes
    localparam int CAPACITY_DEF = 64;
    localparam int TAG_BITS_DEF = 16;

    // field widths
    localparam int CMD_W    = 1;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int TAG_W    = 16;
    localparam int RIDX_W   = 6;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int KEY_W    = MONTH_W + DAY_W + HOUR_W + MINUTE_W;

    // date limits
    localparam int MAX_MONTH = 12;
    localparam int MAX_DAY   = 31;

    // commands
    localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
    localparam logic [CMD_W-1:0] CMD_READ   = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_END     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    // month, day, hour, minute packed so numeric order is date order
    function automatic logic [KEY_W-1:0] pack_key(
        input logic [MONTH_W-1:0]  month,
        input logic [DAY_W-1:0]    day,
        input logic [HOUR_W-1:0]   hour,
        input logic [MINUTE_W-1:0] minute
    );
        return {month, day, hour, minute};
    endfunction

endpackage

@@ src/sdkt_if.sv @@
// ----------------------------------------------------------------------------
// sdkt_in_if / sdkt_out_if - command and result channels
// Valid/ready channels; a transaction moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface sdkt_in_if;
    logic                            valid;
    logic                            ready;
    logic [sdkt_pkg::CMD_W-1:0]      cmd;
    logic [sdkt_pkg::MONTH_W-1:0]    month;
    logic [sdkt_pkg::DAY_W-1:0]      day;
    logic [sdkt_pkg::HOUR_W-1:0]     hour;
    logic [sdkt_pkg::MINUTE_W-1:0]   minute;
    logic [sdkt_pkg::TAG_W-1:0]      tag;
    logic [sdkt_pkg::RIDX_W-1:0]     read_index;

    modport source (output valid, cmd, month, day, hour, minute, tag, read_index,
                    input ready);
    modport sink   (input valid, cmd, month, day, hour, minute, tag, read_index,
                    output ready);
endinterface

interface sdkt_out_if;
    logic                            valid;
    logic                            ready;
    logic [sdkt_pkg::STATUS_W-1:0]   status;
    logic [sdkt_pkg::POS_W-1:0]      position;
    logic [sdkt_pkg::MONTH_W-1:0]    out_month;
    logic [sdkt_pkg::DAY_W-1:0]      out_day;
    logic [sdkt_pkg::HOUR_W-1:0]     out_hour;
    logic [sdkt_pkg::MINUTE_W-1:0]   out_minute;
    logic [sdkt_pkg::TAG_W-1:0]      out_tag;
    logic [sdkt_pkg::COUNT_W-1:0]    entry_count;

    modport source (output valid, status, position, out_month, out_day, out_hour,
                    out_minute, out_tag, entry_count, input ready);
    modport sink   (input valid, status, position, out_month, out_day, out_hour,
                    out_minute, out_tag, entry_count, output ready);
endinterface

@@ src/sorted_date_key_table_core.sv @@
// Timing: a read returns through the registered RAM read port; an empty read or a
//   rejected insert answers straight from idle; an accepted insert walks the table.
// Flow: one transaction at a time.
// Reset: synchronous active low; clears state, fill count and result valid.
//   The entry memory is not initialised and needs no clearing pass.
// ----------------------------------------------------------------------------
// sorted_date_key_table_core - date sorted entry table
// Holds up to CAPACITY (key, tag) entries in ascending key order in one
// synchronous RAM. Inserts walk down from the top, moving every entry whose
// key is >= the new key up one slot, then drop the new entry into the hole.
// ----------------------------------------------------------------------------
module sorted_date_key_table_core #(
    parameter int CAPACITY = sdkt_pkg::CAPACITY_DEF,
    parameter int TAG_BITS = sdkt_pkg::TAG_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdkt_in_if.sink     i_in,
    sdkt_out_if.source  o_out
);

    localparam int KEY_W = sdkt_pkg::KEY_W;
    localparam int ENT_W = KEY_W + TAG_BITS;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // width for comparing read_index against the fill count
    localparam int CMP_W = (CNT_W > sdkt_pkg::RIDX_W) ? CNT_W : sdkt_pkg::RIDX_W;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;  // read data returning from RAM
    localparam logic [1:0] S_SHIFT = 2'd2;  // compare; move one entry up or write the new entry
    localparam logic [1:0] S_PLACE = 2'd3;  // write new entry into the hole

    // ------------------------------------------------------------------------
    // Entry RAM: {key, tag} per slot, one write and one registered read port
    // ------------------------------------------------------------------------
    logic [ENT_W-1:0] r_mem [CAPACITY];
    logic [ENT_W-1:0] r_rdata;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [ENT_W-1:0] w_wdata;
    logic [IDX_W-1:0] w_raddr;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // ------------------------------------------------------------------------
    // Control and result registers
    // ------------------------------------------------------------------------
    logic [1:0]                      r_state, n_state;
    logic [CNT_W-1:0]                r_fill, n_fill;
    logic [IDX_W-1:0]                r_j, n_j;       // hole / read slot
    logic [KEY_W-1:0]                r_key, n_key;   // key being inserted
    logic [TAG_BITS-1:0]             r_tag, n_tag;
    logic                            r_out_valid, n_out_valid;
    logic [sdkt_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [sdkt_pkg::POS_W-1:0]      r_pos, n_pos;
    logic [KEY_W-1:0]                r_out_key, n_out_key;
    logic [sdkt_pkg::TAG_W-1:0]      r_out_tag, n_out_tag;
    logic [sdkt_pkg::COUNT_W-1:0]    r_count, n_count;

    logic                            w_accept;
    logic [KEY_W-1:0]                w_new_key;
    logic [31:0]                     w_tag_in32;
    logic [31:0]                     w_tag_rd32;
    logic [KEY_W-1:0]                w_rd_key;
    logic [TAG_BITS-1:0]             w_rd_tag;
    logic                            w_ridx_ok;

    assign w_rd_key   = r_rdata[ENT_W-1 -: KEY_W];
    assign w_rd_tag   = r_rdata[TAG_BITS-1:0];
    assign w_tag_in32 = 32'(i_in.tag);
    assign w_tag_rd32 = 32'(w_rd_tag);
    assign w_new_key  = sdkt_pkg::pack_key(i_in.month, i_in.day, i_in.hour, i_in.minute);
    assign w_ridx_ok  = CMP_W'(i_in.read_index) < CMP_W'(r_fill);

    // one transaction in flight; the output register must be free or draining
    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_j         = r_j;
        n_key       = r_key;
        n_tag       = r_tag;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_pos       = r_pos;
        n_out_key   = r_out_key;
        n_out_tag   = r_out_tag;
        n_count     = r_count;
        w_we        = 1'b0;
        w_waddr     = r_j;
        w_wdata     = {r_key, r_tag};
        w_raddr     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // defaults for an immediate result
                    n_pos     = '0;
                    n_out_key = '0;
                    n_out_tag = '0;
                    n_count   = sdkt_pkg::COUNT_W'(r_fill);
                    if (i_in.cmd == sdkt_pkg::CMD_READ) begin
                        if (w_ridx_ok) begin
                            n_j     = IDX_W'(i_in.read_index);
                            w_raddr = IDX_W'(i_in.read_index);
                            n_state = S_READ;
                        end else begin
                            n_status    = sdkt_pkg::ST_EMPTY;
                            n_pos       = i_in.read_index;
                            n_out_valid = 1'b1;
                        end
                    end else if (r_fill == CNT_W'(CAPACITY)) begin
                        n_status    = sdkt_pkg::ST_FULL;
                        n_out_valid = 1'b1;
                    end else if (i_in.month == '0 || i_in.day == '0) begin
                        n_status    = sdkt_pkg::ST_END;
                        n_out_valid = 1'b1;
                    end else if (i_in.month > sdkt_pkg::MONTH_W'(sdkt_pkg::MAX_MONTH) ||
                                 {1'b0, i_in.day} >
                                 (sdkt_pkg::DAY_W + 1)'(sdkt_pkg::MAX_DAY)) begin
                        n_status    = sdkt_pkg::ST_INVALID;
                        n_out_valid = 1'b1;
                    end else begin
                        n_key = w_new_key;
                        n_tag = w_tag_in32[TAG_BITS-1:0];
                        n_j   = IDX_W'(r_fill);
                        if (r_fill == '0) begin
                            n_state = S_PLACE;
                        end else begin
                            // fetch the current top entry
                            w_raddr = IDX_W'(r_fill - CNT_W'(1));
                            n_state = S_SHIFT;
                        end
                    end
                end
            end

            S_READ: begin
                n_status    = sdkt_pkg::ST_OK;
                n_pos       = sdkt_pkg::POS_W'(r_j);
                n_out_key   = w_rd_key;
                n_out_tag   = w_tag_rd32[sdkt_pkg::TAG_W-1:0];
                n_count     = sdkt_pkg::COUNT_W'(r_fill);
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end

            S_SHIFT: begin
                // r_rdata holds entry r_j-1
                w_we    = 1'b1;
                w_waddr = r_j;
                if (w_rd_key >= r_key) begin
                    // move it up; a new entry goes ahead of equal keys
                    w_wdata = r_rdata;
                    n_j     = r_j - IDX_W'(1);
                    if (r_j == IDX_W'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        w_raddr = r_j - IDX_W'(1) - IDX_W'(1);
                    end
                end else begin
                    w_wdata     = {r_key, r_tag};
                    n_fill      = r_fill + CNT_W'(1);
                    n_status    = sdkt_pkg::ST_OK;
                    n_pos       = sdkt_pkg::POS_W'(r_j);
                    n_out_key   = '0;
                    n_out_tag   = '0;
                    n_count     = sdkt_pkg::COUNT_W'(n_fill);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            S_PLACE: begin
                w_we        = 1'b1;
                w_waddr     = r_j;
                w_wdata     = {r_key, r_tag};
                n_fill      = r_fill + CNT_W'(1);
                n_status    = sdkt_pkg::ST_OK;
                n_pos       = sdkt_pkg::POS_W'(r_j);
                n_out_key   = '0;
                n_out_tag   = '0;
                n_count     = sdkt_pkg::COUNT_W'(n_fill);
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_j       <= n_j;
        r_key     <= n_key;
        r_tag     <= n_tag;
        r_status  <= n_status;
        r_pos     <= n_pos;
        r_out_key <= n_out_key;
        r_out_tag <= n_out_tag;
        r_count   <= n_count;
    end

    // result channel
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.position    = r_pos;
    assign o_out.out_month   = r_out_key[KEY_W-1 -: sdkt_pkg::MONTH_W];
    assign o_out.out_day     = r_out_key[sdkt_pkg::MINUTE_W + sdkt_pkg::HOUR_W +: sdkt_pkg::DAY_W];
    assign o_out.out_hour    = r_out_key[sdkt_pkg::MINUTE_W +: sdkt_pkg::HOUR_W];
    assign o_out.out_minute  = r_out_key[sdkt_pkg::MINUTE_W-1:0];
    assign o_out.out_tag     = r_out_tag;
    assign o_out.entry_count = r_count;

endmodule
